// File: rtl/core/swpec_pkg.sv
// Shared types and constants for the sliding-window peak event counter.
// No dependencies; used by the controller, the datapath and the top level.
package swpec_pkg;

   localparam int DEPTH_DEFAULT      = 256;
   localparam int TIME_WIDTH_DEFAULT = 32;

   localparam int TS_W       = 32;   // timestamp field width
   localparam int WIN_W      = 32;   // window_seconds register width
   localparam int CNT_OUT_W  = 9;    // count fields on the result word
   localparam int RSP_DATA_W = 24;   // result tdata, padded to whole bytes

   localparam logic [WIN_W-1:0] WINDOW_RESET = 32'd60;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // take the word on the input, append it
      logic drop;     // retire the oldest entry
      logic finish;   // load the result register, clear the run if last
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic drop_needed;
   } status_type;

endpackage

// File: rtl/core/sliding_window_peak_event_count_top.sv
// Sliding-window peak event counter: one event timestamp in, one count word out.
// After the input word is taken, the scan retires the out-of-window entries one at a time
// through the one-read store port, then loads the result register and raises result valid.
// A new input word is taken only once the scan for the last one has finished.
// A pending result does not block the next input; a stalled result holds the scan.
// Reset (synchronous, active high) clears pointers, counts, flags; window returns to 60.
// The timestamp store is not cleared; only entries written in the current run are read.
module sliding_window_peak_event_count_top #(
   parameter int WINDOW_DEPTH = swpec_pkg::DEPTH_DEFAULT,
   parameter int TIME_WIDTH   = swpec_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [swpec_pkg::WIN_W-1:0]        csr_wr_data,   // window_seconds
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [swpec_pkg::TS_W-1:0]         req_tdata,     // [31:0] timestamp
   input  logic                               req_tlast,     // last_request
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [8:0] window_count, [17:9] peak_count, [18] overflowed, [23:19] zero
   output logic [swpec_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                               rsp_tlast      // run_end
);
   import swpec_pkg::*;

   cmd_type                cmd;
   status_type             status;
   logic [CNT_OUT_W-1:0]   window_count;
   logic [CNT_OUT_W-1:0]   peak_count;
   logic                   overflowed;

   swpec_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   swpec_dp #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .TIME_WIDTH   (TIME_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_timestamp    (req_tdata),
      .req_last         (req_tlast),
      .cmd              (cmd),
      .status           (status),
      .rsp_window_count (window_count),
      .rsp_peak_count   (peak_count),
      .rsp_overflowed   (overflowed),
      .rsp_run_end      (rsp_tlast)
   );

   assign rsp_tdata = {{(RSP_DATA_W - 2*CNT_OUT_W - 1){1'b0}}, overflowed,
                       peak_count, window_count};

endmodule

// File: rtl/core/swpec_ctrl.sv
// Controller for the sliding-window peak event counter.
// Sequences append, drop scan and result load; depends on swpec_pkg.
module swpec_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  swpec_pkg::status_type status,
   output swpec_pkg::cmd_type    cmd
);
   import swpec_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      req_tready   = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.drop_needed) begin
               cmd.drop = 1'b1;
            end else if (!rsp_valid_ff || rsp_tready) begin
               // result register is free or being emptied this cycle
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_finish_room: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded while output word still pending");

   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.drop && cmd.finish) && !(cmd.load && (cmd.drop || cmd.finish)))
      else $error("conflicting datapath commands");

   a_load_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_SCAN && !req_tready))
      else $error("append not followed by scan");

endmodule

// File: rtl/core/swpec_dp.sv
// Datapath for the sliding-window peak event counter: timestamp store,
// head/tail pointers, counts, window register and result register. Uses swpec_pkg.
module swpec_dp #(
   parameter int WINDOW_DEPTH = swpec_pkg::DEPTH_DEFAULT,
   parameter int TIME_WIDTH   = swpec_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [swpec_pkg::WIN_W-1:0]       csr_wr_data,
   input  logic [swpec_pkg::TS_W-1:0]        req_timestamp,
   input  logic                              req_last,
   input  swpec_pkg::cmd_type                cmd,
   output swpec_pkg::status_type             status,
   output logic [swpec_pkg::CNT_OUT_W-1:0]   rsp_window_count,
   output logic [swpec_pkg::CNT_OUT_W-1:0]   rsp_peak_count,
   output logic                              rsp_overflowed,
   output logic                              rsp_run_end
);
   import swpec_pkg::*;

   localparam int PTR_W = $clog2(WINDOW_DEPTH);
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int CMP_W = (TIME_WIDTH > WIN_W) ? TIME_WIDTH : WIN_W;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_DEPTH);

   function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   logic [TIME_WIDTH-1:0] mem [WINDOW_DEPTH];
   logic [TIME_WIDTH-1:0] rd_data_ff;
   logic [PTR_W-1:0]      rd_addr;

   logic [WIN_W-1:0]      window_ff;
   logic [TIME_WIDTH-1:0] ts_ff;
   logic                  last_ff;
   logic [PTR_W-1:0]      head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0]      count_ff, count_in, best_ff, best_in;
   logic                  ovf_ff, ovf_in;

   logic [TIME_WIDTH-1:0] ts_new;
   logic                  full;
   logic [PTR_W-1:0]      head_ev;
   logic [TIME_WIDTH-1:0] diff;
   logic [CNT_W-1:0]      peak;

   assign ts_new  = TIME_WIDTH'(req_timestamp);
   assign full    = (count_ff == CNT_FULL);
   assign head_ev = full ? nxt(head_ff) : head_ff;
   assign diff    = ts_ff - rd_data_ff;
   assign peak    = (count_ff > best_ff) ? count_ff : best_ff;

   assign status.drop_needed = (count_ff > CNT_W'(1)) &&
                               (CMP_W'(diff) > CMP_W'(window_ff));

   // read ahead so the entry at the head is always in rd_data_ff
   always_comb begin
      if (cmd.load) begin
         rd_addr = head_ev;
      end else if (cmd.drop) begin
         rd_addr = nxt(head_ff);
      end else begin
         rd_addr = head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mem[tail_ff] <= ts_new;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      best_in  = best_ff;
      ovf_in   = ovf_ff;
      if (cmd.load) begin
         head_in  = head_ev;
         tail_in  = nxt(tail_ff);
         count_in = full ? count_ff : count_ff + CNT_W'(1);
         ovf_in   = ovf_ff | full;
      end else if (cmd.drop) begin
         head_in  = nxt(head_ff);
         count_in = count_ff - CNT_W'(1);
      end else if (cmd.finish) begin
         best_in = peak;
         if (last_ff) begin
            head_in  = '0;
            tail_in  = '0;
            count_in = '0;
            best_in  = '0;
            ovf_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         best_ff   <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            window_ff <= csr_wr_data;
         end
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         best_ff  <= best_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ts_ff   <= ts_new;
         last_ff <= req_last;
      end
      if (cmd.finish) begin
         rsp_window_count <= CNT_OUT_W'(count_ff);
         rsp_peak_count   <= CNT_OUT_W'(peak);
         rsp_overflowed   <= ovf_ff;
         rsp_run_end      <= last_ff;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("held count beyond store depth");

   a_drop_keeps_one: assert property (@(posedge clock) disable iff (reset)
      cmd.drop |-> count_ff > CNT_W'(1))
      else $error("newest entry dropped");

   a_run_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && last_ff) |=> (count_ff == '0 && best_ff == '0 && !ovf_ff))
      else $error("run state not cleared after last word");

   a_ptr_span: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty store with pointers apart");

endmodule

// File: sim/tb_sliding_window_peak_event_count_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for sliding_window_peak_event_count_top.
// Depends on swpec_pkg and the top-level RTL.
// An in-bench window tracker predicts each result word.

module tb_sliding_window_peak_event_count_top;
   import swpec_pkg::*;

   localparam int STORE_DEPTH  = DEPTH_DEFAULT;
   localparam int LONG_HOLD    = 600;
   localparam int RANDOM_WORDS = 1300;
   localparam int PHASES       = 8;

   class window_tally;
      typedef struct {
         logic [CNT_OUT_W-1:0] count;
         logic [CNT_OUT_W-1:0] peak;
         logic                 ovf;
         logic                 run_end;
      } tally_type;

      logic [TS_W-1:0]  stamps[STORE_DEPTH];
      int               head;
      int               tail;
      int               held;
      int               best;
      logic             ovf;
      logic [WIN_W-1:0] window_len;
      tally_type        due_tallies[$];
      int               errors;

      function new();
         clear_run();
         window_len = WINDOW_RESET;
         errors     = 0;
      endfunction

      function void clear_run();
         head = 0;
         tail = 0;
         held = 0;
         best = 0;
         ovf  = 1'b0;
      endfunction

      function void set_window(logic [WIN_W-1:0] value);
         window_len = value;
      endfunction

      function int pending();
         return due_tallies.size();
      endfunction

      // Append the stamp, retire what has fallen out of the window, queue the result.
      function void note_word(logic [TS_W-1:0] stamp, logic last);
         logic [TS_W-1:0] age;
         tally_type       t;
         if (held >= STORE_DEPTH) begin
            head = (head + 1) % STORE_DEPTH;
            held--;
            ovf = 1'b1;
         end
         stamps[tail] = stamp;
         tail = (tail + 1) % STORE_DEPTH;
         held++;
         while (held > 1) begin
            age = stamp - stamps[head];
            if (age <= window_len) break;
            head = (head + 1) % STORE_DEPTH;
            held--;
         end
         if (held > best) best = held;
         t.count   = CNT_OUT_W'(held);
         t.peak    = CNT_OUT_W'(best);
         t.ovf     = ovf;
         t.run_end = last;
         due_tallies.push_back(t);
         if (last) clear_run();
      endfunction

      function void check_word(logic [RSP_DATA_W-1:0] data, logic last);
         tally_type t;
         if (due_tallies.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: unexpected result word %h last=%b", $realtime, data, last);
            return;
         end
         t = due_tallies.pop_front();
         if (data[8:0] !== t.count || data[17:9] !== t.peak || data[18] !== t.ovf
             || last !== t.run_end) begin
            errors++;
            if (errors <= 10)
               $display({"%0t: mismatch exp count=%0d peak=%0d ovf=%b end=%b,",
                         " got count=%0d peak=%0d ovf=%b end=%b"},
                        $realtime, t.count, t.peak, t.ovf, t.run_end,
                        data[8:0], data[17:9], data[18], last);
         end
      endfunction

      function void flag_leftover();
         if (due_tallies.size() != 0) begin
            errors++;
            if (errors <= 10)
               $display("%0d result words never arrived", due_tallies.size());
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [WIN_W-1:0]      csr_wr_data;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [TS_W-1:0]       req_tdata;     // [31:0] timestamp
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;     // [8:0] count, [17:9] peak, [18] overflow
   logic                  rsp_tlast;

   window_tally board = new();
   bit          hold_rsp;
   int          send_calm;
   int          sink_calm;

   sliding_window_peak_event_count_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
   function automatic int pick_gap(ref int calm_left);
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [TS_W-1:0] next_stamp(logic [TS_W-1:0] prev,
                                                  logic [WIN_W-1:0] win);
      int              r;
      logic [TS_W-1:0] span;
      span = (win > 32'd200) ? 32'd200 : win;
      r = $urandom_range(0, 99);
      if (r < 15) return prev;
      if (r < 55) return prev + $urandom_range(0, span);
      if (r < 80) return prev + $urandom_range(0, 3);
      // land just inside, on, or just past the window edge
      if (r < 92) return prev + win + $urandom_range(0, 2) - 1;
      if (r < 97) return prev + $urandom_range(0, 32'h00FF_FFFF);
      return $urandom();
   endfunction

   task automatic send_word(input logic [TS_W-1:0] stamp, input logic last);
      int gap;
      gap = pick_gap(send_calm);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = stamp;
      req_tlast  = last;
      do @(posedge clock); while (req_tready !== 1'b1);
      board.note_word(stamp, last);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_window(input logic [WIN_W-1:0] value);
      drain_results();
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      board.set_window(value);
   endtask

   task automatic send_run(input int len, input logic [WIN_W-1:0] win);
      logic [TS_W-1:0] stamp;
      int              r;
      r = $urandom_range(0, 9);
      if (r < 6)      stamp = $urandom();
      else if (r < 8) stamp = 32'hFFFF_FFFF - $urandom_range(0, 400);
      else            stamp = $urandom_range(0, 400);
      for (int i = 0; i < len; i++) begin
         if (i > 0) stamp = next_stamp(stamp, win);
         send_word(stamp, i == len - 1);
      end
   endtask

   function automatic int pick_run_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8)  return 1;
      if (r < 85) return $urandom_range(2, 40);
      if (r < 95) return $urandom_range(41, 120);
      return $urandom_range(257, 300);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         board.check_word(rsp_tdata, rsp_tlast);
   end

   initial begin : result_sink
      int stall;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            // hold off long enough for the block to back up into its input
            rsp_tready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_rsp   = 1'b0;
            rsp_tready = 1'b1;
         end else begin
            stall = pick_gap(sink_calm);
            if (stall > 0) begin
               rsp_tready = 1'b0;
               repeat (stall) @(negedge clock);
            end
            rsp_tready = 1'b1;
         end
      end
   end

   initial begin : stimulus
      logic [WIN_W-1:0] phase_win[PHASES];
      int               phase_words;
      int               run_len;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      hold_rsp    = 1'b0;
      send_calm   = 0;
      sink_calm   = 0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // default window of 60: edge of window, drop-all, equal stamps, going backwards, wrap
      send_word(32'd0, 1'b0);
      send_word(32'd30, 1'b0);
      send_word(32'd60, 1'b0);
      send_word(32'd61, 1'b0);
      send_word(32'd200, 1'b0);
      send_word(32'd200, 1'b0);
      send_word(32'd100, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'h0000_0010, 1'b0);
      send_word(32'h0000_0020, 1'b1);
      send_word(32'h5555_5555, 1'b0);
      send_word(32'hAAAA_AAAA, 1'b1);

      write_window(32'd1);
      send_word(32'd1000, 1'b0);
      send_word(32'd1000, 1'b0);
      send_word(32'd1001, 1'b0);
      send_word(32'd1002, 1'b1);

      write_window(32'hFFFF_FFFF);
      send_word(32'd0, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'd7, 1'b1);

      phase_win[0] = 32'hFFFF_FFFF;
      phase_win[1] = 32'd5;
      phase_win[2] = $urandom_range(10, 1000);
      phase_win[3] = 32'd1;
      phase_win[4] = $urandom();
      phase_win[5] = 32'd60;
      phase_win[6] = 32'd3600;
      phase_win[7] = $urandom_range(2, 50);

      for (int p = 0; p < PHASES; p++) begin
         write_window(phase_win[p]);
         phase_words = 0;
         while (phase_words < RANDOM_WORDS / PHASES) begin
            // first run under the widest window overfills the store
            run_len = (p == 0 && phase_words == 0) ? 280 : pick_run_len();
            if (p == 2 && phase_words == 0) hold_rsp = 1'b1;
            if (p == 5 && phase_words > 60 && phase_words < 120) drain_results();
            send_run(run_len, phase_win[p]);
            phase_words += run_len;
         end
      end

      drain_results();
      repeat (20) @(posedge clock);
      board.flag_leftover();
      if (board.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : watchdog
      #(20_000_000);
      $display("Test completed with failures");
      $finish;
   end

endmodule
